// ----- sv/qfpt_pkg.sv -----
// Package for the quadrilateral fill pixel test: coordinate widths, the vertex
// type, register indexes and the pipeline stage enable struct.
// Depends on nothing.
`timescale 1ns / 1ps

package qfpt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int PIX_W       = 15;
  localparam int COLOR_W     = 24;
  localparam int XY_W        = 2 * COORD_WIDTH;
  localparam int CFG_DW      = (XY_W > COLOR_W) ? XY_W : COLOR_W;
  localparam int CFG_IW      = 3;

  localparam int VDW = COORD_WIDTH + 1;
  localparam int DW  = ((COORD_WIDTH > PIX_W) ? COORD_WIDTH : PIX_W) + 2;
  localparam int PW  = VDW + DW;
  localparam int NW  = PW + 3;

  localparam logic [CFG_IW-1:0] REG_VERTEX0    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_VERTEX1    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_VERTEX2    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_VERTEX3    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FILL_COLOR = 3'd4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } qfpt_vertex_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } qfpt_stage_en_t;

endpackage

// ----- sv/qfpt_cfg_regs.sv -----
// Configuration register file: four vertex registers and the fill color.
// Depends on qfpt_pkg.
`timescale 1ns / 1ps

module qfpt_cfg_regs import qfpt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_write_en,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_wdata,
  output qfpt_vertex_t [3:0]      vtx,
  output logic [COLOR_W-1:0]      fill_color
);

  qfpt_vertex_t [3:0]   vtx_r;
  logic [COLOR_W-1:0]   color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r   <= '0;
      color_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_VERTEX0:    vtx_r[0] <= cfg_wdata[XY_W-1:0];
        REG_VERTEX1:    vtx_r[1] <= cfg_wdata[XY_W-1:0];
        REG_VERTEX2:    vtx_r[2] <= cfg_wdata[XY_W-1:0];
        REG_VERTEX3:    vtx_r[3] <= cfg_wdata[XY_W-1:0];
        REG_FILL_COLOR: color_r  <= cfg_wdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign vtx        = vtx_r;
  assign fill_color = color_r;

endmodule

// ----- sv/qfpt_tri_pipe.sv -----
// Four-stage barycentric test of one pixel against one triangle: differences,
// products, edge sums, then sign and magnitude checks. Depends on qfpt_pkg.
`timescale 1ns / 1ps

module qfpt_tri_pipe import qfpt_pkg::*; (
  input  logic               clk,
  input  qfpt_stage_en_t     en,
  input  qfpt_vertex_t       v0,
  input  qfpt_vertex_t       v1,
  input  qfpt_vertex_t       v2,
  input  logic [PIX_W-1:0]   pixel_x,
  input  logic [PIX_W-1:0]   pixel_y,
  output logic               hit
);

  function automatic logic unit_ratio(input logic signed [NW-1:0] n,
                                      input logic signed [NW-1:0] den);
    logic ok;
    ok = 1'b0;
    if (den > 0) begin
      ok = (n >= 0) && (n <= den);
    end else if (den < 0) begin
      ok = (n <= 0) && (n >= den);
    end
    return ok;
  endfunction

  logic signed [VDW-1:0] a_r, b_r, c_r, d_r, f_r;
  logic signed [DW-1:0]  dx_r, dy_r;
  logic signed [PW-1:0]  p_ad_r, p_bf_r, p_adx_r, p_bdy_r, p_cdx_r, p_ddy_r;
  logic signed [NW-1:0]  den_r, na_r, nb_r;
  logic signed [NW-1:0]  den4_r, nc_r;
  logic                  ok_ab_r;
  logic signed [NW-1:0]  nc_nxt;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a_r  <= VDW'(v1.y) - VDW'(v2.y);
      b_r  <= VDW'(v2.x) - VDW'(v1.x);
      c_r  <= VDW'(v2.y) - VDW'(v0.y);
      d_r  <= VDW'(v0.x) - VDW'(v2.x);
      f_r  <= VDW'(v0.y) - VDW'(v2.y);
      dx_r <= $signed(DW'(pixel_x)) - DW'(v2.x);
      dy_r <= $signed(DW'(pixel_y)) - DW'(v2.y);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_ad_r  <= PW'(a_r) * PW'(d_r);
      p_bf_r  <= PW'(b_r) * PW'(f_r);
      p_adx_r <= PW'(a_r) * PW'(dx_r);
      p_bdy_r <= PW'(b_r) * PW'(dy_r);
      p_cdx_r <= PW'(c_r) * PW'(dx_r);
      p_ddy_r <= PW'(d_r) * PW'(dy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      den_r <= NW'(p_ad_r) + NW'(p_bf_r);
      na_r  <= NW'(p_adx_r) + NW'(p_bdy_r);
      nb_r  <= NW'(p_cdx_r) + NW'(p_ddy_r);
    end
  end

  assign nc_nxt = den_r - na_r - nb_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      den4_r  <= den_r;
      nc_r    <= nc_nxt;
      ok_ab_r <= unit_ratio(na_r, den_r) && unit_ratio(nb_r, den_r);
    end
  end

  assign hit = ok_ab_r && unit_ratio(nc_r, den4_r);

endmodule

// ----- sv/quad_fill_pixel_test_top.sv -----
// Quadrilateral fill pixel test. Each pixel request is tested against four
// triangles of the quadrilateral set by the vertex registers, and one pixel
// write comes back per request, with the fill color when the pixel lies inside
// and zero color otherwise. The block takes one request per cycle while the output
// side is not stalled, and returns each result through the four register stages of
// the triangle units (differences, six multipliers per triangle, edge sums, range
// checks) and the output register. Each stage holds only while the stage after it
// is full and stalled, so bubbles close up.
// Depends on qfpt_pkg, qfpt_cfg_regs and qfpt_tri_pipe.
`timescale 1ns / 1ps

module quad_fill_pixel_test_top import qfpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_pixel_x,
  input  logic [PIX_W-1:0]    in_pixel_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_write_enable,
  output logic [PIX_W-1:0]    out_x,
  output logic [PIX_W-1:0]    out_y,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);

  qfpt_vertex_t [3:0]   vtx;
  logic [COLOR_W-1:0]   fill_color;
  qfpt_stage_en_t       en;
  logic                 en_out;
  logic [3:0]           tri_hit;
  logic                 hit;

  logic                 v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [PIX_W-1:0]     px1_r, px2_r, px3_r, px4_r;
  logic [PIX_W-1:0]     py1_r, py2_r, py3_r, py4_r;
  logic                 we_r;
  logic [PIX_W-1:0]     ox_r, oy_r;
  logic [COLOR_W-1:0]   color_r;

  qfpt_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .vtx          (vtx),
    .fill_color   (fill_color)
  );

  assign en_out = !out_valid_r || out_ready;
  assign en.s4  = !v4_r || en_out;
  assign en.s3  = !v3_r || en.s4;
  assign en.s2  = !v2_r || en.s3;
  assign en.s1  = !v1_r || en.s2;
  assign in_ready = en.s1;

  qfpt_tri_pipe u_tri_012 (
    .clk(clk), .en(en), .v0(vtx[0]), .v1(vtx[1]), .v2(vtx[2]),
    .pixel_x(in_pixel_x), .pixel_y(in_pixel_y), .hit(tri_hit[0])
  );

  qfpt_tri_pipe u_tri_032 (
    .clk(clk), .en(en), .v0(vtx[0]), .v1(vtx[3]), .v2(vtx[2]),
    .pixel_x(in_pixel_x), .pixel_y(in_pixel_y), .hit(tri_hit[1])
  );

  qfpt_tri_pipe u_tri_312 (
    .clk(clk), .en(en), .v0(vtx[3]), .v1(vtx[1]), .v2(vtx[2]),
    .pixel_x(in_pixel_x), .pixel_y(in_pixel_y), .hit(tri_hit[2])
  );

  qfpt_tri_pipe u_tri_013 (
    .clk(clk), .en(en), .v0(vtx[0]), .v1(vtx[1]), .v2(vtx[3]),
    .pixel_x(in_pixel_x), .pixel_y(in_pixel_y), .hit(tri_hit[3])
  );

  assign hit = |tri_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      px1_r <= in_pixel_x;
      py1_r <= in_pixel_y;
    end
    if (en.s2) begin
      px2_r <= px1_r;
      py2_r <= py1_r;
    end
    if (en.s3) begin
      px3_r <= px2_r;
      py3_r <= py2_r;
    end
    if (en.s4) begin
      px4_r <= px3_r;
      py4_r <= py3_r;
    end
    if (en_out) begin
      we_r    <= hit;
      ox_r    <= px4_r;
      oy_r    <= py4_r;
      color_r <= hit ? fill_color : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_red          = color_r[23:16];
  assign out_green        = color_r[15:8];
  assign out_blue         = color_r[7:0];

`ifndef SYNTH
  a_no_color_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_red == 8'd0 && out_green == 8'd0 &&
    out_blue == 8'd0)
    else $error("pixel write without hit carries a color");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && out_valid_r)
    else $error("request refused while a stage is empty");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en.s4 |=> v4_r)
    else $error("request lost between stage three and stage four");
`endif

endmodule

// ----- tb/quad_fill_pixel_test_top_tb.sv -----
// Testbench for quad_fill_pixel_test_top: random and directed pixel requests checked
// against an inside-quadrilateral predictor kept in a small scoreboard class.
// Depends on qfpt_pkg and the quad_fill_pixel_test_top RTL.
`timescale 1ns / 1ps

module quad_fill_pixel_test_top_tb;
  import qfpt_pkg::*;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 10;
  localparam int PIX_MAX          = (1 << PIX_W) - 1;
  localparam int RANDOM_SETTINGS  = 14;

  typedef enum int {NEAR_QUAD, RAW_BITS, DEGENERATE, EXTREMES} quad_shape_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} rx_pattern_t;

  typedef struct {
    logic             write_enable;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } pixel_write_t;

  class pixel_write_board_t;
    qfpt_vertex_t       vtx[4];
    logic [COLOR_W-1:0] color;
    pixel_write_t       expected_writes[$];
    int                 errors;
    int                 checked;
    int                 hits;

    function new();
      for (int k = 0; k < 4; k++) vtx[k] = '0;
      color   = '0;
      errors  = 0;
      checked = 0;
      hits    = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_VERTEX0, REG_VERTEX1, REG_VERTEX2, REG_VERTEX3: begin
          vtx[idx[1:0]] = data[XY_W-1:0];
        end
        REG_FILL_COLOR: begin
          color = data[COLOR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function bit unit_ratio(longint n, longint den);
      if (den > 0) return n >= 0 && n <= den;
      if (den < 0) return n <= 0 && n >= den;
      return 1'b0;
    endfunction

    function bit triangle_holds(int a, int b, int c, longint px, longint py);
      longint x0, y0, x1, y1, x2, y2, den, na, nb, nc;
      x0  = longint'(vtx[a].x);
      y0  = longint'(vtx[a].y);
      x1  = longint'(vtx[b].x);
      y1  = longint'(vtx[b].y);
      x2  = longint'(vtx[c].x);
      y2  = longint'(vtx[c].y);
      den = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
      na  = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
      nb  = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
      nc  = den - na - nb;
      return unit_ratio(na, den) && unit_ratio(nb, den) && unit_ratio(nc, den);
    endfunction

    function void note_request(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pixel_write_t w;
      logic         in_quad;
      longint       lx, ly;
      lx = longint'(px);
      ly = longint'(py);
      in_quad = triangle_holds(0, 1, 2, lx, ly) || triangle_holds(0, 3, 2, lx, ly) ||
                triangle_holds(3, 1, 2, lx, ly) || triangle_holds(0, 1, 3, lx, ly);
      w.write_enable = in_quad;
      w.x            = px;
      w.y            = py;
      w.red          = in_quad ? color[23:16] : 8'd0;
      w.green        = in_quad ? color[15:8] : 8'd0;
      w.blue         = in_quad ? color[7:0] : 8'd0;
      expected_writes = {expected_writes, w};
    endfunction

    function void compare(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
        $error("%s: expected %0d, got %0d", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(logic we, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_write_t w;
      if (expected_writes.size() == 0) begin
        $error("pixel write with no request outstanding: x %0d y %0d", x, y);
        errors++;
        return;
      end
      w = expected_writes.pop_front();
      checked++;
      if (w.write_enable) hits++;
      compare("write_enable", 32'(w.write_enable), 32'(we));
      compare("out_x", 32'(w.x), 32'(x));
      compare("out_y", 32'(w.y), 32'(y));
      compare("red", 32'(w.red), 32'(r));
      compare("green", 32'(w.green), 32'(g));
      compare("blue", 32'(w.blue), 32'(b));
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_write_en     = 1'b0;
  logic [CFG_IW-1:0]   cfg_index        = '0;
  logic [CFG_DW-1:0]   cfg_wdata        = '0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [PIX_W-1:0]    in_pixel_x       = '0;
  logic [PIX_W-1:0]    in_pixel_y       = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic                out_write_enable;
  logic [PIX_W-1:0]    out_x;
  logic [PIX_W-1:0]    out_y;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;

  pixel_write_board_t sb = new();

  int          hold_requests = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  int          pattern_left  = 0;
  int          rx_count      = 0;
  rx_pattern_t rx_pattern    = RX_ALWAYS;
  int          settings      = 0;

  quad_fill_pixel_test_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      sb.check_result(out_write_enable, out_x, out_y, out_red, out_green, out_blue);
    end
  end

  always @(posedge clk) begin
    if (hold_left == 0 && holds_done != hold_requests) begin
      holds_done++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern   = rx_pattern_t'($urandom_range(RX_ALWAYS, RX_RARE_STALL));
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      rx_count++;
      case (rx_pattern)
        RX_ALWAYS:       out_ready <= 1'b1;
        RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: out_ready <= (rx_count % 4) != 0;
        default:         out_ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  function automatic logic [XY_W-1:0] vert(int x, int y);
    qfpt_vertex_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    return v;
  endfunction

  function automatic int clamp_pix(int v);
    if (v < 0) return 0;
    if (v > PIX_MAX) return PIX_MAX;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_quad(logic [XY_W-1:0] v0, logic [XY_W-1:0] v1, logic [XY_W-1:0] v2,
                          logic [XY_W-1:0] v3, logic [CFG_DW-1:0] color_word);
    logic [CFG_IW-1:0] spare_idx;
    drain();
    write_reg(REG_VERTEX0, v0);
    write_reg(REG_VERTEX1, v1);
    write_reg(REG_VERTEX2, v2);
    write_reg(REG_VERTEX3, v3);
    write_reg(REG_FILL_COLOR, color_word);
    if ($urandom_range(0, 1)) begin
      spare_idx = CFG_IW'($urandom_range(int'(REG_FILL_COLOR) + 1, (1 << CFG_IW) - 1));
      write_reg(spare_idx, $urandom());
    end
    settings++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(px, py);
  endtask

  task automatic run_pixels(int count);
    int               xlo, xhi, ylo, yhi, vxk, vyk, burst, gap, sel, k;
    logic [PIX_W-1:0] px, py;
    xlo = int'(sb.vtx[0].x);
    xhi = xlo;
    ylo = int'(sb.vtx[0].y);
    yhi = ylo;
    for (int n = 1; n < 4; n++) begin
      vxk = int'(sb.vtx[n].x);
      vyk = int'(sb.vtx[n].y);
      if (vxk < xlo) xlo = vxk;
      if (vxk > xhi) xhi = vxk;
      if (vyk < ylo) ylo = vyk;
      if (vyk > yhi) yhi = vyk;
    end
    xlo = clamp_pix(xlo - 4);
    xhi = clamp_pix(xhi + 4);
    ylo = clamp_pix(ylo - 4);
    yhi = clamp_pix(yhi + 4);
    burst = $urandom_range(1, 60);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        px = PIX_W'($urandom());
        py = PIX_W'($urandom());
      end else if (sel == 2) begin
        k  = $urandom_range(0, 3);
        px = PIX_W'(clamp_pix(int'(sb.vtx[k].x)));
        py = PIX_W'(clamp_pix(int'(sb.vtx[k].y)));
      end else begin
        px = PIX_W'($urandom_range(xlo, xhi));
        py = PIX_W'($urandom_range(ylo, yhi));
      end
      send_pixel(px, py);
      burst--;
      if (burst == 0 && i < count - 1) begin
        burst = $urandom_range(1, 60);
        gap   = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [XY_W-1:0]    vw[4];
    logic [COLOR_W-1:0] fill;
    quad_shape_t        shape;
    int                 cx, cy, r, dx, dy, pick, coord[2];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(0, 0);
    send_pixel(PIX_W'(PIX_MAX), PIX_W'(PIX_MAX));
    in_valid <= 1'b0;

    set_quad(vert(100, 100), vert(300, 100), vert(300, 300), vert(100, 300), 32'hAB123456);
    send_pixel(200, 200);
    send_pixel(100, 100);
    send_pixel(300, 200);
    send_pixel(99, 200);
    send_pixel(301, 301);
    send_pixel(0, 0);
    send_pixel(PIX_W'(PIX_MAX), PIX_W'(PIX_MAX));
    in_valid <= 1'b0;

    set_quad(vert(-32768, -32768), vert(32767, -32768), vert(32767, 32767),
             vert(-32768, 32767), 32'h00FFFFFF);
    send_pixel(0, 0);
    send_pixel(PIX_W'(PIX_MAX), 0);
    send_pixel(0, PIX_W'(PIX_MAX));
    send_pixel(PIX_W'(PIX_MAX), PIX_W'(PIX_MAX));
    send_pixel(16383, 21845);
    in_valid <= 1'b0;

    set_quad(vert(0, 0), vert(100, 100), vert(200, 200), vert(300, 300), 32'hFF00FF00);
    send_pixel(50, 50);
    send_pixel(150, 150);
    send_pixel(10, 20);
    in_valid <= 1'b0;

    set_quad(vert(1000, 1000), vert(1000, 1000), vert(2000, 1000), vert(1000, 2000),
             32'h0000FF80);
    send_pixel(1200, 1200);
    send_pixel(1000, 1000);
    send_pixel(1600, 1600);
    in_valid <= 1'b0;

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      shape = quad_shape_t'(p % 4);
      cx    = $urandom_range(0, PIX_MAX);
      cy    = $urandom_range(0, PIX_MAX);
      r     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(16, 2000);
      for (int k = 0; k < 4; k++) begin
        case (shape)
          NEAR_QUAD: begin
            vw[k] = vert(cx - r + $urandom_range(0, 2 * r), cy - r + $urandom_range(0, 2 * r));
          end
          RAW_BITS: begin
            vw[k] = $urandom();
          end
          DEGENERATE: begin
            vw[k] = vert(cx - r + $urandom_range(0, 2 * r), cy - r + $urandom_range(0, 2 * r));
          end
          default: begin
            for (int c = 0; c < 2; c++) begin
              pick = $urandom_range(0, 3);
              case (pick)
                0:       coord[c] = -32768;
                1:       coord[c] = 32767;
                2:       coord[c] = 0;
                default: coord[c] = $urandom_range(0, PIX_MAX);
              endcase
            end
            vw[k] = vert(coord[0], coord[1]);
          end
        endcase
      end
      if (shape == DEGENERATE) begin
        if ($urandom_range(0, 1)) begin
          dx = $urandom_range(0, 2 * r) - r;
          dy = $urandom_range(0, 2 * r) - r;
          for (int k = 0; k < 4; k++) vw[k] = vert(cx + k * dx, cy + k * dy);
        end else begin
          vw[$urandom_range(0, 3)] = vw[$urandom_range(0, 3)];
        end
      end
      case ($urandom_range(0, 4))
        0:       fill = '0;
        1:       fill = '1;
        default: fill = COLOR_W'($urandom());
      endcase
      set_quad(vw[0], vw[1], vw[2], vw[3], {8'($urandom()), fill});
      if (p == 3 || p == 9) hold_requests++;
      run_pixels($urandom_range(90, 130));
    end

    drain();
    $display("Checked %0d pixel writes over %0d quadrilateral settings, %0d of them inside.",
             sb.checked, settings, sb.hits);
    $display("Receiver stalls included %0d long holds against a busy sender.", holds_done);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d pixel writes still outstanding.", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
